// ===== rtl/core/mwsl_pkg.sv =====
package mwsl_pkg;

  // fixed field widths
  localparam int IN_W       = 16;
  localparam int SPD_W      = 17;
  localparam int STEPS_W    = 5;
  localparam int RADIUS_W   = 10;
  localparam int BASE_W     = 12;
  localparam int MAXSPD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // internal widths that do not depend on the fraction size
  localparam int MAG_HI_W = 21;   // |v| * 60 < 2^21
  localparam int D_W      = 20;   // 1000 * radius
  localparam int HALF_D_W = 19;   // 500 * radius
  localparam int LIM_W    = 36;   // (max + 1) * 1000 * radius
  localparam int RH_W     = 33;   // lever arm times integer part of yaw
  localparam int QUO_W    = 16;   // final speed magnitude
  localparam int CNT_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 2'd2;

  // wheel order: front right, front left, back left, back right
  localparam logic [3:0] WHEEL_SIDE_MINUS = 4'b1010;
  localparam logic [3:0] WHEEL_YAW_MINUS  = 4'b0110;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_LIMIT  = 15'h0002,
    S_THR    = 15'h0004,
    S_LIN    = 15'h0008,
    S_PM     = 15'h0010,
    S_ROT    = 15'h0020,
    S_WHEEL  = 15'h0040,
    S_DECIDE = 15'h0080,
    S_SCALE  = 15'h0100,
    S_DIV_N  = 15'h0200,
    S_DIV_A  = 15'h0400,
    S_DIV_L  = 15'h0800,
    S_DIV_I  = 15'h1000,
    S_DIV_W  = 15'h2000,
    S_OUT    = 15'h4000
  } state_t;

endpackage

// ===== rtl/core/mecanum_wheel_speed_limiter.sv =====
// Mecanum four-wheel inverse kinematics with iterative speed limiting. A body
// command (vel_forward, vel_side in mm/s, yaw_rate in mrad/s) is scaled by 60
// and turned into four wheel speeds (+-vx +-vy +-k*w/1000)/r, rounded to the
// nearest integer. While any |speed| is above max_wheel_speed the scale drops
// by 0.0333334 and the velocity vector is multiplied by it again (compounding),
// up to MAX_STEPS times; if the limit is still missed, all speeds come out zero
// with gave_up set. One command is processed at a time and cmd_stall stays high
// meanwhile. Each limit test forms the wheel numerators and tests one wheel per
// cycle; each reduction first runs the three velocities through the shared
// multiplier, then forms the yaw product again before the next test. The final
// rounding runs a 16-step bit-serial divider per wheel. The result register
// holds its beat while the next command is already being worked on.
module mecanum_wheel_speed_limiter
  import mwsl_pkg::*;
#(
  parameter int MAX_STEPS = 30,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // command channel
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic signed [IN_W-1:0]       vel_forward,
  input  logic signed [IN_W-1:0]       vel_side,
  input  logic signed [IN_W-1:0]       yaw_rate,
  // wheel speed channel
  output logic                         spd_valid,
  input  logic                         spd_stall,
  output logic signed [SPD_W-1:0]      speed_front_right,
  output logic signed [SPD_W-1:0]      speed_front_left,
  output logic signed [SPD_W-1:0]      speed_back_left,
  output logic signed [SPD_W-1:0]      speed_back_right,
  output logic [STEPS_W-1:0]           scale_steps,
  output logic                         gave_up
);

  // widths that follow the fraction size
  localparam int F       = FRAC_BITS;
  localparam int VMAG_W  = MAG_HI_W + F;                 // velocity magnitude
  localparam int MA_W    = (F > MAG_HI_W) ? F : MAG_HI_W; // multiplier port a
  localparam int MB_W    = (F + 1 > 17) ? F + 1 : 17;    // multiplier port b
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SCALE_W = F + 1;
  localparam int LIN_W   = VMAG_W + 2;                   // +-vx +-vy
  localparam int P_W     = LIN_W + 10;                   // 1000 * lin
  localparam int ROT_W   = VMAG_W + BASE_W;              // k * |w|
  localparam int NW      = VMAG_W + 17;                  // wheel numerator
  localparam int AM_W    = NW - 1 - F;                   // |numerator| >> F

  // scale constants in Q1.F
  localparam logic [63:0] STEP_WIDE =
    ((64'd333334 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam logic [SCALE_W-1:0] STEP_Q = STEP_WIDE[SCALE_W-1:0];
  localparam logic [SCALE_W-1:0] ONE_Q  = {1'b1, {F{1'b0}}};

  // configuration registers
  logic [RADIUS_W-1:0]  wheel_radius_mm;
  logic [BASE_W-1:0]    half_base_sum_mm;
  logic [MAXSPD_W-1:0]  max_wheel_speed;

  // sequencer and working registers
  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           widx;
  logic [VMAG_W-1:0]    vxm, vym, vwm;
  logic                 vx_neg, vy_neg, vw_neg;
  logic [SCALE_W-1:0]   scale;
  logic [STEPS_W-1:0]   steps;
  logic                 quit;
  logic                 fail;
  logic [PROD_W-1:0]    prod;
  logic [VMAG_W-1:0]    acc;
  logic [LIM_W-1:0]     thr;
  logic signed [NW-1:0] tneg;
  logic signed [LIN_W-1:0] lin_p, lin_m;
  logic signed [P_W-1:0]   p_reg, m_reg;
  logic [RH_W-1:0]      rot_hi;
  logic [ROT_W-1:0]     rot_mag;
  logic signed [NW-1:0] nreg;
  logic                 nneg;
  logic [AM_W-1:0]      amag;
  logic [AM_W-1:0]      rem;
  logic [AM_W-1:0]      dsh;
  logic [QUO_W-1:0]     quo;
  logic signed [SPD_W-1:0] spd [4];

  // combinational helpers
  logic                 cmd_take;
  logic                 out_load;
  logic [RADIUS_W-1:0]  r_eff;
  logic [D_W-1:0]       dval;
  logic [HALF_D_W-1:0]  half_d;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic signed [LIN_W-1:0] vxs, vys;
  logic signed [NW-1:0] tpos;
  logic signed [NW-1:0] base_n, rot_n, n_cur;
  logic                 rot_sub;
  logic                 over;
  logic [NW-1:0]        nabs;
  logic [VMAG_W-1:0]    scaled;

  // |x| * 60 in Q.F
  function automatic logic [VMAG_W-1:0] load_mag(input logic signed [IN_W-1:0] x);
    logic [IN_W:0]       a;
    logic [MAG_HI_W-1:0] m;
    a = x[IN_W-1] ? (IN_W + 1)'(-{x[IN_W-1], x}) : {1'b0, x};
    m = (MAG_HI_W'(a) << 6) - (MAG_HI_W'(a) << 2);
    return VMAG_W'(m) << F;
  endfunction

  function automatic logic signed [P_W-1:0] times1000(input logic signed [LIN_W-1:0] x);
    logic signed [P_W-1:0] e;
    e = P_W'(x);
    return (e <<< 10) - (e <<< 5) + (e <<< 3);
  endfunction

  function automatic logic [SPD_W-1:0] spd_mag(input logic signed [SPD_W-1:0] x);
    return x[SPD_W-1] ? SPD_W'(-x) : SPD_W'(x);
  endfunction

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign out_load  = (state == S_OUT) && (!spd_valid || !spd_stall);

  // radius zero acts as one
  assign r_eff  = (wheel_radius_mm == '0) ? RADIUS_W'(1) : wheel_radius_mm;
  assign dval   = (D_W'(r_eff) << 10) - (D_W'(r_eff) << 5) + (D_W'(r_eff) << 3);
  assign half_d = dval[D_W-1:1];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LIMIT: begin
        mul_a = MA_W'(dval);
        mul_b = MB_W'(17'(max_wheel_speed) + 17'd1);
      end
      S_LIN: begin
        mul_a = MA_W'(vwm[VMAG_W-1:F]);
        mul_b = MB_W'(half_base_sum_mm);
      end
      S_PM: begin
        mul_a = MA_W'(vwm[F-1:0]);
        mul_b = MB_W'(half_base_sum_mm);
      end
      S_SCALE: begin
        mul_b = MB_W'(scale);
        unique case (cnt[2:0])
          3'd0:    mul_a = MA_W'(vxm[VMAG_W-1:F]);
          3'd1:    mul_a = MA_W'(vxm[F-1:0]);
          3'd2:    mul_a = MA_W'(vym[VMAG_W-1:F]);
          3'd3:    mul_a = MA_W'(vym[F-1:0]);
          3'd4:    mul_a = MA_W'(vwm[VMAG_W-1:F]);
          3'd5:    mul_a = MA_W'(vwm[F-1:0]);
          default: mul_a = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // signed velocities for the linear terms
  assign vxs = vx_neg ? -$signed(LIN_W'(vxm)) : $signed(LIN_W'(vxm));
  assign vys = vy_neg ? -$signed(LIN_W'(vym)) : $signed(LIN_W'(vym));

  // wheel numerator for the wheel under test, and the limit test on it:
  // |n| >= thr << F is the same as rounded speed above the limit
  assign tpos    = $signed(NW'(thr) << F);
  assign base_n  = WHEEL_SIDE_MINUS[widx] ? NW'(m_reg) : NW'(p_reg);
  assign rot_n   = $signed(NW'(rot_mag));
  assign rot_sub = WHEEL_YAW_MINUS[widx] ^ vw_neg;
  assign n_cur   = rot_sub ? (base_n - rot_n) : (base_n + rot_n);
  assign over    = (n_cur >= tpos) || (n_cur <= tneg);

  assign nabs   = nreg[NW-1] ? NW'(-nreg) : NW'(nreg);
  assign scaled = acc + VMAG_W'(prod >> F);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius_mm  <= RADIUS_W'(50);
      half_base_sum_mm <= BASE_W'(200);
      max_wheel_speed  <= MAXSPD_W'(300);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:   wheel_radius_mm  <= cfg_data[RADIUS_W-1:0];
        CFG_BASE_SUM: half_base_sum_mm <= cfg_data[BASE_W-1:0];
        CFG_MAX_SPD:  max_wheel_speed  <= cfg_data[MAXSPD_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier product register
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      spd_valid <= 1'b0;
    end else begin
      // a beat taken this cycle clears valid unless a new one replaces it
      if (spd_valid && !spd_stall && !out_load) begin
        spd_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            vxm    <= load_mag(vel_forward);
            vym    <= load_mag(vel_side);
            vwm    <= load_mag(yaw_rate);
            vx_neg <= vel_forward[IN_W-1];
            vy_neg <= vel_side[IN_W-1];
            vw_neg <= yaw_rate[IN_W-1];
            scale  <= ONE_Q;
            steps  <= '0;
            quit   <= 1'b0;
            state  <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          // (max + 1) * 1000 * r issued this cycle
          state <= S_THR;
        end
        S_THR: begin
          thr   <= LIM_W'(prod) - LIM_W'(half_d);
          state <= S_LIN;
        end
        S_LIN: begin
          lin_p <= vxs + vys;
          lin_m <= vxs - vys;
          tneg  <= -tpos;
          state <= S_PM;
        end
        S_PM: begin
          p_reg  <= times1000(lin_p);
          m_reg  <= times1000(lin_m);
          rot_hi <= prod[RH_W-1:0];
          state  <= S_ROT;
        end
        S_ROT: begin
          rot_mag <= (ROT_W'(rot_hi) << F) + ROT_W'(prod);
          fail    <= 1'b0;
          widx    <= '0;
          state   <= S_WHEEL;
        end
        S_WHEEL: begin
          fail <= fail | over;
          widx <= widx + 2'd1;
          if (widx == 2'd3) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (!fail) begin
            widx  <= '0;
            state <= S_DIV_N;
          end else if (steps >= STEPS_W'(MAX_STEPS)) begin
            quit  <= 1'b1;
            state <= S_OUT;
          end else begin
            steps <= steps + STEPS_W'(1);
            scale <= (scale > STEP_Q) ? (scale - STEP_Q) : '0;
            cnt   <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // odd slots take the integer-part product, even slots add the
          // fraction-part product and write the velocity back
          cnt <= cnt + CNT_W'(1);
          if (cnt[0]) begin
            acc <= VMAG_W'(prod);
          end else begin
            unique case (cnt[2:1])
              2'd1:    vxm <= scaled;
              2'd2:    vym <= scaled;
              2'd3:    vwm <= scaled;
              default: ;
            endcase
          end
          if (cnt[2:0] == 3'd6) begin
            state <= S_LIN;
          end
        end
        S_DIV_N: begin
          nreg  <= n_cur;
          state <= S_DIV_A;
        end
        S_DIV_A: begin
          amag  <= nabs[NW-2:F];
          nneg  <= nreg[NW-1];
          state <= S_DIV_L;
        end
        S_DIV_L: begin
          // round half up: (|n| >> F) + 500r over 1000r
          rem   <= amag + AM_W'(half_d);
          dsh   <= AM_W'(dval) << (QUO_W - 1);
          quo   <= '0;
          cnt   <= CNT_W'(QUO_W - 1);
          state <= S_DIV_I;
        end
        S_DIV_I: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          spd[widx] <= nneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          widx      <= widx + 2'd1;
          state     <= (widx == 2'd3) ? S_OUT : S_DIV_N;
        end
        S_OUT: begin
          if (out_load) begin
            speed_front_right <= quit ? '0 : spd[0];
            speed_front_left  <= quit ? '0 : spd[1];
            speed_back_left   <= quit ? '0 : spd[2];
            speed_back_right  <= quit ? '0 : spd[3];
            scale_steps       <= steps;
            gave_up           <= quit;
            spd_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // reduction count never passes its budget while a command is in work
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (steps <= STEPS_W'(MAX_STEPS)))
    else $error("reduction count above budget");

  // a give-up beat carries zero speeds and a full reduction count
  a_gave_up_zero: assert property (@(posedge clk) disable iff (rst)
    (spd_valid && gave_up) |->
      (speed_front_right == '0 && speed_front_left == '0 &&
       speed_back_left == '0 && speed_back_right == '0 &&
       scale_steps == STEPS_W'(MAX_STEPS)))
    else $error("give-up beat with nonzero speeds");

  // every delivered speed respects the limit unless the block gave up
  a_limit_met: assert property (@(posedge clk) disable iff (rst)
    (spd_valid && !gave_up) |->
      (spd_mag(speed_front_right) <= SPD_W'(max_wheel_speed) &&
       spd_mag(speed_front_left) <= SPD_W'(max_wheel_speed) &&
       spd_mag(speed_back_left) <= SPD_W'(max_wheel_speed) &&
       spd_mag(speed_back_right) <= SPD_W'(max_wheel_speed)))
    else $error("wheel speed above limit");

  // divider remainder stays below twice the current shifted divisor
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_I) |-> (rem < {dsh, 1'b0}))
    else $error("divider quotient overflow");

endmodule

// ===== tb/sv/tb_mecanum_wheel_speed_limiter.sv =====
`timescale 1ns / 1ps

module tb_mecanum_wheel_speed_limiter;
  import mwsl_pkg::*;

  // block defaults: reduction budget and fraction bits of the fixed point
  localparam int     RED_BUDGET = 30;
  localparam int     FRAC       = 16;
  localparam longint ONE_SCALE  = longint'(1) << FRAC;
  // 0.0333334 in the scale format, rounded to nearest
  localparam longint SCALE_DEC  = ((longint'(333334) << FRAC) + 5000000) / 10000000;
  // register index the block has no register for
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int     CYCLE_LIMIT = 2500000;
  localparam int     IDLE_PCT    = 29;

  typedef struct {
    logic signed [IN_W-1:0] fwd;
    logic signed [IN_W-1:0] side;
    logic signed [IN_W-1:0] yaw;
  } body_cmd_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] fr;
    logic signed [SPD_W-1:0] fl;
    logic signed [SPD_W-1:0] bl;
    logic signed [SPD_W-1:0] br;
    logic [STEPS_W-1:0]      steps;
    logic                    quit;
  } wheel_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic signed [IN_W-1:0] vel_forward = '0;
  logic signed [IN_W-1:0] vel_side = '0;
  logic signed [IN_W-1:0] yaw_rate = '0;
  logic spd_valid;
  logic spd_stall = 1'b0;
  logic signed [SPD_W-1:0] speed_front_right;
  logic signed [SPD_W-1:0] speed_front_left;
  logic signed [SPD_W-1:0] speed_back_left;
  logic signed [SPD_W-1:0] speed_back_right;
  logic [STEPS_W-1:0] scale_steps;
  logic gave_up;

  // our own copy of the configuration registers
  logic [RADIUS_W-1:0] radius_mm = 10'd50;
  logic [BASE_W-1:0]   lever_mm  = 12'd200;
  logic [MAXSPD_W-1:0] speed_cap = 16'd300;

  body_cmd_t  cmd_q[$];       // commands waiting for the driver
  wheel_set_t wheel_due_q[$]; // predicted wheel sets, oldest first
  int  n_queued = 0;
  int  n_taken = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  cmd_taken = 1'b0;
  bit  no_idle = 1'b0;

  mecanum_wheel_speed_limiter uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd_valid         (cmd_valid),
    .cmd_stall         (cmd_stall),
    .vel_forward       (vel_forward),
    .vel_side          (vel_side),
    .yaw_rate          (yaw_rate),
    .spd_valid         (spd_valid),
    .spd_stall         (spd_stall),
    .speed_front_right (speed_front_right),
    .speed_front_left  (speed_front_left),
    .speed_back_left   (speed_back_left),
    .speed_back_right  (speed_back_right),
    .scale_steps       (scale_steps),
    .gave_up           (gave_up)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // magnitude times scale, shifted down, truncated toward zero
  function automatic longint apply_scale(input longint v, input longint s);
    longint a;
    longint m;
    a = (v < 0) ? -v : v;
    m = (a >>> FRAC) * s + (((a & (ONE_SCALE - 1)) * s) >>> FRAC);
    return (v < 0) ? -m : m;
  endfunction

  // one wheel speed, rounded to nearest with ties away from zero
  function automatic longint wheel_speed(input longint vx, input longint vy,
                                         input longint vw, input int wheel);
    longint lin;
    longint rot;
    longint num;
    longint den;
    longint a;
    longint q;
    lin = WHEEL_SIDE_MINUS[wheel] ? vx - vy : vx + vy;
    rot = longint'(lever_mm) * vw;
    num = 1000 * lin + (WHEEL_YAW_MINUS[wheel] ? -rot : rot);
    // zero radius acts as one
    den = (1000 * ((radius_mm == 0) ? longint'(1) : longint'(radius_mm))) << FRAC;
    a = (num < 0) ? -num : num;
    q = (a + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // wheel speeds after the compounding scale reductions
  function automatic wheel_set_t limit_wheel_speeds(input body_cmd_t c);
    longint v[3];
    longint spd[4];
    longint scale;
    int steps;
    bit over;
    bit quit;
    bit done;
    wheel_set_t res;
    v[0] = longint'(c.fwd) * 60 * ONE_SCALE;
    v[1] = longint'(c.side) * 60 * ONE_SCALE;
    v[2] = longint'(c.yaw) * 60 * ONE_SCALE;
    scale = ONE_SCALE;
    steps = 0;
    quit = 1'b0;
    done = 1'b0;
    while (!done) begin
      over = 1'b0;
      for (int w = 0; w < 4; w++) begin
        spd[w] = wheel_speed(v[0], v[1], v[2], w);
        if (((spd[w] < 0) ? -spd[w] : spd[w]) > longint'(speed_cap))
          over = 1'b1;
      end
      if (!over) begin
        done = 1'b1;
      end else if (steps >= RED_BUDGET) begin
        quit = 1'b1;
        done = 1'b1;
      end else begin
        steps++;
        // scale saturates at zero, which zeroes every speed
        scale = (scale > SCALE_DEC) ? scale - SCALE_DEC : 0;
        for (int i = 0; i < 3; i++)
          v[i] = apply_scale(v[i], scale);
      end
    end
    res.fr = quit ? '0 : spd[0][SPD_W-1:0];
    res.fl = quit ? '0 : spd[1][SPD_W-1:0];
    res.bl = quit ? '0 : spd[2][SPD_W-1:0];
    res.br = quit ? '0 : spd[3][SPD_W-1:0];
    res.steps = steps[STEPS_W-1:0];
    res.quit = quit;
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // command driver: hold a beat until it is taken, then maybe idle
  always @(negedge clk) begin : cmd_drive
    body_cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (cmd_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = cmd_q.pop_front();
        cmd_valid <= 1'b1;
        vel_forward <= nxt.fwd;
        vel_side <= nxt.side;
        yaw_rate <= nxt.yaw;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random, except in the calm stretch
  always @(negedge clk) begin
    spd_stall <= !rst && !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // predict on every taken command, check every taken result beat
  always @(posedge clk) begin : monitor
    body_cmd_t c;
    wheel_set_t want;
    cmd_taken <= !rst && cmd_valid && !cmd_stall;
    if (!rst && cmd_valid && !cmd_stall) begin
      c.fwd = vel_forward;
      c.side = vel_side;
      c.yaw = yaw_rate;
      wheel_due_q.push_back(limit_wheel_speeds(c));
      n_taken++;
    end
    if (!rst && spd_valid && !spd_stall) begin
      if (wheel_due_q.size() == 0) begin
        $display("%0t: unexpected beat fr %0d fl %0d bl %0d br %0d steps %0d gave_up %0d",
                 $time, speed_front_right, speed_front_left, speed_back_left,
                 speed_back_right, scale_steps, gave_up);
        errors++;
      end else begin
        want = wheel_due_q.pop_front();
        check_field("speed_front_right", $signed(want.fr), speed_front_right);
        check_field("speed_front_left", $signed(want.fl), speed_front_left);
        check_field("speed_back_left", $signed(want.bl), speed_back_left);
        check_field("speed_back_right", $signed(want.br), speed_back_right);
        check_field("scale_steps", want.steps, scale_steps);
        check_field("gave_up", want.quit, gave_up);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_cmd(input logic signed [IN_W-1:0] f, input logic signed [IN_W-1:0] s,
                           input logic signed [IN_W-1:0] y);
    body_cmd_t c;
    c.fwd = f;
    c.side = s;
    c.yaw = y;
    cmd_q.push_back(c);
    n_queued++;
  endtask

  // register write, mirrored into our copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS:   radius_mm = data[RADIUS_W-1:0];
      CFG_BASE_SUM: lever_mm = data[BASE_W-1:0];
      CFG_MAX_SPD:  speed_cap = data[MAXSPD_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every command is taken and every wheel set has come back
  task automatic settle(input int tail);
    while (!(n_taken == n_queued && wheel_due_q.size() == 0))
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // mix of tiny, moderate, full range and corner velocities
  function automatic logic signed [IN_W-1:0] rand_vel();
    int mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return '0;
          default: return -16'sd1;
        endcase
      end
      1, 2, 3: mag = $urandom_range(0, 300);
      4, 5, 6: mag = $urandom_range(0, 5000);
      default: return $signed(IN_W'($urandom));
    endcase
    return $signed(IN_W'($urandom_range(0, 1) ? -mag : mag));
  endfunction

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: zero, pure axes, corners, unit steps
    queue_cmd(0, 0, 0);
    queue_cmd(100, 0, 0);
    queue_cmd(0, 100, 0);
    queue_cmd(0, 0, 1000);
    queue_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    queue_cmd(16'sh7fff, 16'sh8000, 0);
    queue_cmd(-1, -1, -1);
    queue_cmd(1, 1, 1);
    settle(4);

    // zero radius, longest lever, zero limit: deepest reductions toward
    // scale underflow; the unused index must leave everything alone
    write_reg(CFG_RADIUS, 16'h0000);
    write_reg(CFG_BASE_SUM, 16'h0fff);
    write_reg(CFG_MAX_SPD, 16'h0000);
    write_reg(CFG_UNUSED, 16'hffff);
    queue_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    queue_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_cmd(1, 0, 0);
    queue_cmd(0, 0, 16'sh8000);
    queue_cmd(16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_cmd(0, 0, 0);
    settle(4);

    // largest radius, no lever, widest limit; upper data bits get dropped
    write_reg(CFG_RADIUS, 16'hffff);
    write_reg(CFG_BASE_SUM, 16'hf000);
    write_reg(CFG_MAX_SPD, 16'hffff);
    queue_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    queue_cmd(0, 0, 16'sh7fff);
    queue_cmd(12345, -23456, 555);
    settle(4);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RADIUS, 16'd50);
          write_reg(CFG_BASE_SUM, 16'd200);
          write_reg(CFG_MAX_SPD, 16'd300);
        end
        1: begin
          write_reg(CFG_RADIUS, 16'd1);
          write_reg(CFG_BASE_SUM, 16'd4095);
          write_reg(CFG_MAX_SPD, 16'd0);
        end
        2: begin
          write_reg(CFG_RADIUS, 16'd1023);
          write_reg(CFG_BASE_SUM, 16'd0);
          write_reg(CFG_MAX_SPD, 16'd65535);
        end
        4: begin
          write_reg(CFG_RADIUS, 16'($urandom_range(0, 200)));
          write_reg(CFG_BASE_SUM, CFG_DATA_W'($urandom));
          write_reg(CFG_MAX_SPD, 16'($urandom_range(0, 1000)));
        end
        default: begin
          write_reg(CFG_RADIUS, CFG_DATA_W'($urandom));
          write_reg(CFG_BASE_SUM, CFG_DATA_W'($urandom));
          write_reg(CFG_MAX_SPD, CFG_DATA_W'($urandom));
        end
      endcase
      write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      // one phase runs with neither side idling
      no_idle = (ph == 3);
      for (int n = 0; n < 125; n++)
        queue_cmd(rand_vel(), rand_vel(), rand_vel());
      settle(4);
    end
    no_idle = 1'b0;

    // let any stray beat show up before the verdict
    settle(200);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
